[rtl/kmer_window_minimizer_assert.svh]
// Assertion macros used by the k-mer minimizer RTL.
// No dependencies; included by kmer_window_minimizer.sv for its concurrent checks.
`ifndef KMER_WINDOW_MINIMIZER_ASSERT_SVH
`define KMER_WINDOW_MINIMIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KWM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("kmer_window_minimizer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KWM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("kmer_window_minimizer: next-cycle check failed");

`endif

[rtl/kwm_pkg.sv]
// Package for the k-mer window minimizer: widths, register indexes,
// configuration and status structs. No dependencies.
package kwm_pkg;

    localparam int MAX_KMER    = 31;
    localparam int KMER_W      = 2 * MAX_KMER;
    localparam int SHIFT_W     = $clog2(KMER_W + 1);
    localparam int BASE_W      = 2;
    localparam int READ_W      = 32;
    localparam int KLEN_W      = 5;
    localparam int WLEN_W      = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 96;

    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd1;

    typedef struct packed {
        logic [KLEN_W-1:0] kmer_len;
        logic [WLEN_W-1:0] window_len;
    } kwm_cfg_t;

    typedef struct packed {
        logic [KLEN_W-1:0] bases_seen;
        logic [WLEN_W-1:0] group_fill;
    } kwm_stat_t;

    // Clamp k to 1..MAX_KMER.
    function automatic logic [KLEN_W-1:0] eff_kmer_len(input logic [KLEN_W-1:0] k);
        logic [KLEN_W-1:0] r;
        r = k;
        if (k == '0) begin
            r = KLEN_W'(1);
        end else if (int'(k) > MAX_KMER) begin
            r = KLEN_W'(MAX_KMER);
        end
        return r;
    endfunction

    // Zero window length counts as one.
    function automatic logic [WLEN_W-1:0] eff_window_len(input logic [WLEN_W-1:0] w);
        return (w == '0) ? WLEN_W'(1) : w;
    endfunction

endpackage

[rtl/kwm_core.sv]
// Per-read state of the minimizer: base shift register, k-mer count,
// group fill and running group minimum. Depends on kwm_pkg.
module kwm_core
    import kwm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [BASE_W-1:0] base_code,
    input  logic              read_start,
    input  kwm_cfg_t          cfg,
    output logic              emit,
    output logic [KMER_W-1:0] best_code,
    output kwm_stat_t         stat
);

    logic [KMER_W-1:0]  recent_reg, recent_next;
    logic [KLEN_W-1:0]  seen_reg, seen_next;
    logic [WLEN_W-1:0]  fill_reg, fill_next;
    logic [KMER_W-1:0]  best_reg, best_next;

    logic [KMER_W-1:0]  recent_base, best_base, shifted, kmask, kmer, best_upd;
    logic [KLEN_W-1:0]  seen_base, seen_inc, k_eff;
    logic [WLEN_W-1:0]  fill_base, fill_inc, w_eff;
    logic [SHIFT_W-1:0] mask_shamt;
    logic               kmer_done, take;

    always_comb begin
        k_eff = eff_kmer_len(cfg.kmer_len);
        w_eff = eff_window_len(cfg.window_len);

        // A new read drops everything left from the previous one.
        recent_base = read_start ? '0 : recent_reg;
        seen_base   = read_start ? '0 : seen_reg;
        fill_base   = read_start ? '0 : fill_reg;
        best_base   = read_start ? '0 : best_reg;

        shifted    = {recent_base[KMER_W-BASE_W-1:0], base_code};
        seen_inc   = (seen_base < k_eff) ? seen_base + KLEN_W'(1) : seen_base;
        kmer_done  = !(seen_inc < k_eff);
        mask_shamt = SHIFT_W'(KMER_W) - SHIFT_W'({k_eff, 1'b0});
        kmask      = {KMER_W{1'b1}} >> mask_shamt;
        kmer       = shifted & kmask;

        // Strict compare keeps the earliest k-mer on a tie.
        take     = (fill_base == '0) || (kmer < best_base);
        best_upd = take ? kmer : best_base;
        fill_inc = fill_base + WLEN_W'(1);
        emit     = accept && kmer_done && (!(fill_inc < w_eff) || fill_inc == '0);
        best_code = best_upd;

        recent_next = recent_reg;
        seen_next   = seen_reg;
        fill_next   = fill_reg;
        best_next   = best_reg;
        if (accept) begin
            recent_next = shifted;
            seen_next   = seen_inc;
            fill_next   = fill_base;
            best_next   = best_base;
            if (kmer_done) begin
                best_next = best_upd;
                fill_next = emit ? '0 : fill_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg <= '0;
            seen_reg   <= '0;
            fill_reg   <= '0;
            best_reg   <= '0;
        end else begin
            recent_reg <= recent_next;
            seen_reg   <= seen_next;
            fill_reg   <= fill_next;
            best_reg   <= best_next;
        end
    end

    assign stat.bases_seen = seen_reg;
    assign stat.group_fill = fill_reg;

endmodule

[rtl/kmer_window_minimizer.sv]
// Top level of the k-mer window minimizer: configuration registers,
// stream ports and the output register. Depends on kwm_pkg and kwm_core.
//
// Accepts one base per clock cycle and updates the k-mer and group state in
// the same cycle. A finished group minimum appears on the m_ side in the
// cycle after its closing base is taken and sits in a single output register;
// s_tready stays high while that register is empty or being drained, so the
// sustained rate is one base per cycle, limited by the update loop of the
// 62-bit shift register and running minimum compare. Groups are
// disjoint runs of window_length k-mers; a partial group at the end of a
// read produces nothing. Write configuration only while the stream is idle.
`include "kmer_window_minimizer_assert.svh"

module kmer_window_minimizer
    import kwm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [1:0] base_code, [33:2] read_number
    input  logic                  s_tuser,   // [0] read_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [61:0] minimizer_code, [93:62] minimizer_read
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [KLEN_W-1:0] kmer_length_reg, kmer_length_next;
    logic [WLEN_W-1:0] window_length_reg, window_length_next;
    logic              m_valid_reg, m_valid_next;
    logic [KMER_W-1:0] m_code_reg, m_code_next;
    logic [READ_W-1:0] m_read_reg, m_read_next;

    logic              s_accept;
    logic              core_emit;
    logic [KMER_W-1:0] core_best;
    kwm_cfg_t          core_cfg;
    kwm_stat_t         core_stat;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign core_cfg.kmer_len   = kmer_length_reg;
    assign core_cfg.window_len = window_length_reg;

    kwm_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .base_code  (s_tdata[BASE_W-1:0]),
        .read_start (s_tuser),
        .cfg        (core_cfg),
        .emit       (core_emit),
        .best_code  (core_best),
        .stat       (core_stat)
    );

    always_comb begin
        kmer_length_next   = kmer_length_reg;
        window_length_next = window_length_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_KMER_LENGTH:   kmer_length_next   = cfg_wdata[KLEN_W-1:0];
                CFG_WINDOW_LENGTH: window_length_next = cfg_wdata[WLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_code_next  = m_code_reg;
        m_read_next  = m_read_reg;
        if (core_emit) begin
            m_valid_next = 1'b1;
            m_code_next  = core_best;
            m_read_next  = s_tdata[BASE_W+READ_W-1:BASE_W];
        end else if (m_tready) begin
            // drop the transaction once taken
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_length_reg   <= KLEN_W'(11);
            window_length_reg <= WLEN_W'(1);
            m_valid_reg       <= 1'b0;
        end else begin
            kmer_length_reg   <= kmer_length_next;
            window_length_reg <= window_length_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_code_reg <= m_code_next;
        m_read_reg <= m_read_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - READ_W - KMER_W){1'b0}}, m_read_reg, m_code_reg};

    // A result only ever comes from a base taken in the same cycle.
    `KWM_ASSERT_NOW(a_emit_needs_accept, aclk, aresetn, core_emit, s_accept)
    // The first base of a read cannot close a group unless k is one.
    `KWM_ASSERT_NOW(a_no_emit_on_short_start, aclk, aresetn,
        s_accept && s_tuser && (eff_kmer_len(kmer_length_reg) != KLEN_W'(1)), !core_emit)
    // Closing a group empties it.
    `KWM_ASSERT_NEXT(a_fill_cleared_after_emit, aclk, aresetn, core_emit,
        core_stat.group_fill == '0)

endmodule
